// ===== hw/rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bps_pkg.sv =====
// ---------------------------------------------------------------------------
// BPS patch package
// Types, constants, the CRC-32 byte update and the pointer move shared by the patch core.
// ---------------------------------------------------------------------------
package bps_pkg;

	localparam int SRC_AW = 16;
	localparam int TGT_AW = 16;
	localparam int SRC_DEPTH = 1 << SRC_AW;
	localparam int TGT_DEPTH = 1 << TGT_AW;
	localparam int PTR_W = 18;
	localparam int CNT_W = 17;
	localparam logic [31:0] CRC_POLY = 32'hEDB88320;

	typedef enum logic [1:0] {
		OP_CLEAR = 2'd0,
		OP_LOAD  = 2'd1,
		OP_BEGIN = 2'd2,
		OP_STEP  = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ACT_SOURCE_READ = 2'd0,
		ACT_TARGET_READ = 2'd1,
		ACT_SOURCE_COPY = 2'd2,
		ACT_TARGET_COPY = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_CRC    = 2'd1,
		ST_NO_RUN = 2'd2,
		ST_RANGE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		SEL_ZERO = 2'd0,
		SEL_SRC  = 2'd1,
		SEL_TGT  = 2'd2,
		SEL_LIT  = 2'd3
	} byte_sel_t;

	localparam logic CFG_EXP_CRC  = 1'b0;
	localparam logic CFG_OUT_SIZE = 1'b1;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	function automatic logic [PTR_W-1:0] move_ptr(input logic [PTR_W-1:0] p,
			input logic [PTR_W-1:0] raw);
		logic [PTR_W-1:0] mag;
		mag = {1'b0, raw[PTR_W-1:1]};
		return raw[0] ? (p - mag) : (p + mag);
	endfunction

endpackage

// ===== hw/rtl/bps_patch_apply_core.sv =====
// ---------------------------------------------------------------------------
// BPS patch apply core
// Loads the source image with a running CRC-32 and applies patch actions,
// one output byte per step, from the source RAM, target RAM or literal byte, written to the target RAM.
// ---------------------------------------------------------------------------
// A step result passes through the s1 stage and then the output register.
// Throughput: one item per cycle unless in_stall is raised by out_stall; target copies forward the previous write.
// Each RAM is read once per accepted step.
// Reset: control state and valid flags cleared asynchronously; data registers and RAMs not cleared.
module bps_patch_apply_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [1:0]                  opcode,
	input  logic [7:0]                  data_byte,
	input  logic [1:0]                  action_kind,
	input  logic [bps_pkg::CNT_W-1:0]   run_length,
	input  logic [bps_pkg::PTR_W-1:0]   raw_offset,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [7:0]                  out_byte,
	output logic [15:0]                 out_position,
	output logic [1:0]                  status,
	output logic                        run_done,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic                        cfg_index,
	input  logic [31:0]                 cfg_data
);
	import bps_pkg::*;

	logic [31:0]      exp_crc_q;
	logic [CNT_W-1:0] out_size_q;
	logic [CNT_W-1:0] src_cnt_q;
	logic [31:0]      crc_q;
	logic [PTR_W-1:0] sp_q, tp_q;
	logic [CNT_W-1:0] wp_q;
	action_t          kind_q;
	logic [CNT_W-1:0] left_q;

	logic [7:0] src_mem [SRC_DEPTH];
	logic [7:0] tgt_mem [TGT_DEPTH];
	logic [7:0] src_rd_q, tgt_rd_q;

	logic              s1_valid_s1, s1_wr_s1, s1_done_s1;
	status_t           s1_status_s1;
	byte_sel_t         s1_sel_s1;
	logic [7:0]        s1_lit_s1;
	logic [CNT_W-1:0]  s1_pos_s1;
	logic [TGT_AW-1:0] s1_taddr_s1;

	logic              lw_valid_q;
	logic [TGT_AW-1:0] lw_addr_q;
	logic [7:0]        lw_data_q;

	logic out_valid_q, run_done_q;
	logic [7:0] out_byte_q;
	logic [15:0] out_pos_q;
	status_t out_status_q;

	logic acc, s1_adv, is_step, crc_ok, wr_ok, bad_read, run_ok;
	byte_sel_t sel_c;
	logic [SRC_AW-1:0] src_raddr;
	logic [TGT_AW-1:0] tgt_raddr;
	logic [7:0] byte_c, wr_byte;
	opcode_t op;
	action_t kind_in;

	assign op = opcode_t'(opcode);
	assign kind_in = action_t'(action_kind);
	assign cfg_ready = 1'b1;
	assign s1_adv = !out_valid_q || !out_stall;
	assign in_stall = s1_valid_s1 && !s1_adv;
	assign acc = in_valid && !in_stall;
	assign is_step = acc && op == OP_STEP;
	assign crc_ok = (~crc_q) == exp_crc_q;
	assign run_ok = crc_ok && left_q != '0;
	assign wr_ok = wp_q < out_size_q && 32'(wp_q) < TGT_DEPTH;

	always_comb begin
		sel_c = SEL_ZERO;
		bad_read = 1'b0;
		src_raddr = wp_q[SRC_AW-1:0];
		tgt_raddr = tp_q[TGT_AW-1:0];
		case (kind_q)
			ACT_SOURCE_READ: begin
				if (wp_q < src_cnt_q) sel_c = SEL_SRC;
				else bad_read = 1'b1;
			end
			ACT_TARGET_READ: sel_c = SEL_LIT;
			ACT_SOURCE_COPY: begin
				src_raddr = sp_q[SRC_AW-1:0];
				if (sp_q < PTR_W'(src_cnt_q)) sel_c = SEL_SRC;
				else bad_read = 1'b1;
			end
			ACT_TARGET_COPY: begin
				if (tp_q < PTR_W'(wp_q) && 32'(tp_q) < TGT_DEPTH) sel_c = SEL_TGT;
				else bad_read = 1'b1;
			end
			default: bad_read = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_crc_q <= '0;
			out_size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EXP_CRC:  exp_crc_q <= cfg_data;
				CFG_OUT_SIZE: out_size_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_cnt_q <= '0;
			crc_q <= '1;
			sp_q <= '0;
			tp_q <= '0;
			wp_q <= '0;
			kind_q <= ACT_SOURCE_READ;
			left_q <= '0;
		end else if (acc) begin
			case (op)
				OP_CLEAR: begin
					src_cnt_q <= '0;
					crc_q <= '1;
					sp_q <= '0;
					tp_q <= '0;
					wp_q <= '0;
					kind_q <= ACT_SOURCE_READ;
					left_q <= '0;
				end
				OP_LOAD: begin
					if (32'(src_cnt_q) < SRC_DEPTH) begin
						src_cnt_q <= src_cnt_q + 1'b1;
						crc_q <= crc_byte(crc_q, data_byte);
					end
				end
				OP_BEGIN: begin
					kind_q <= kind_in;
					left_q <= run_length;
					if (kind_in == ACT_SOURCE_COPY) sp_q <= move_ptr(sp_q, raw_offset);
					if (kind_in == ACT_TARGET_COPY) tp_q <= move_ptr(tp_q, raw_offset);
				end
				OP_STEP: begin
					if (run_ok) begin
						left_q <= left_q - 1'b1;
						if (kind_q == ACT_SOURCE_COPY) sp_q <= sp_q + 1'b1;
						if (kind_q == ACT_TARGET_COPY) tp_q <= tp_q + 1'b1;
						if (wr_ok) wp_q <= wp_q + 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && op == OP_LOAD && 32'(src_cnt_q) < SRC_DEPTH)
			src_mem[src_cnt_q[SRC_AW-1:0]] <= data_byte;
		if (is_step)
			src_rd_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && s1_adv && s1_wr_s1)
			tgt_mem[s1_pos_s1[TGT_AW-1:0]] <= wr_byte;
		if (is_step)
			tgt_rd_q <= tgt_mem[tgt_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) s1_valid_s1 <= 1'b0;
		else if (is_step) s1_valid_s1 <= 1'b1;
		else if (s1_adv) s1_valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (is_step) begin
			s1_lit_s1 <= data_byte;
			s1_pos_s1 <= wp_q;
			s1_taddr_s1 <= tgt_raddr;
			s1_wr_s1 <= run_ok && wr_ok;
			s1_done_s1 <= run_ok && left_q == CNT_W'(1);
			s1_sel_s1 <= run_ok ? sel_c : SEL_ZERO;
			if (!crc_ok) s1_status_s1 <= ST_CRC;
			else if (left_q == '0) s1_status_s1 <= ST_NO_RUN;
			else if (bad_read || !wr_ok) s1_status_s1 <= ST_RANGE;
			else s1_status_s1 <= ST_OK;
		end
	end

	always_comb begin
		case (s1_sel_s1)
			SEL_SRC: byte_c = src_rd_q;
			SEL_TGT: byte_c = (lw_valid_q && lw_addr_q == s1_taddr_s1) ? lw_data_q : tgt_rd_q;
			SEL_LIT: byte_c = s1_lit_s1;
			default: byte_c = 8'd0;
		endcase
	end
	assign wr_byte = s1_wr_s1 ? byte_c : 8'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) lw_valid_q <= 1'b0;
		else if (s1_valid_s1 && s1_adv && s1_wr_s1) lw_valid_q <= 1'b1;
	end

	always_ff @(posedge clk) begin
		if (s1_valid_s1 && s1_adv && s1_wr_s1) begin
			lw_addr_q <= s1_pos_s1[TGT_AW-1:0];
			lw_data_q <= wr_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (s1_adv) out_valid_q <= s1_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && s1_valid_s1) begin
			out_byte_q <= wr_byte;
			out_pos_q <= s1_pos_s1[15:0];
			out_status_q <= s1_status_s1;
			run_done_q <= s1_done_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign out_position = out_pos_q;
	assign status = out_status_q;
	assign run_done = run_done_q;

`include "assert_macros.svh"

	`ASSERT_NEXT(a_s1_hold, s1_valid_s1 && !s1_adv, s1_valid_s1, "stalled step lost")
	`ASSERT_CLK(a_err_zero, !out_valid_q || out_status_q == ST_OK || out_byte_q == 8'd0, "flagged byte not zero")
	`ASSERT_NEXT(a_clear, acc && op == OP_CLEAR, wp_q == '0 && left_q == '0 && src_cnt_q == '0, "clear incomplete")
	`ASSERT_CLK(a_err_done, !out_valid_q || !run_done_q || out_status_q == ST_OK || out_status_q == ST_RANGE, "run_done on rejected step")

endmodule
